FILE: src/dedup_tag_collector_defines.svh
// Assertion macros used by the tag collector checker.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DEDUP_TAG_COLLECTOR_DEFINES_SVH
`define DEDUP_TAG_COLLECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dtc_pkg.sv
// Shared types and codes of the deduplicating tag collector.
// No dependencies; imported by the interface users, the cells and the checker.
`timescale 1ns / 1ps

package dtc_pkg;

  localparam int OP_W     = 2;
  localparam int TAG_W    = 64;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [TAG_W-1:0] tag_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    popped_tag;
    logic [COUNT_W-1:0]  held_tags;
  } out_item_t;

  // Command broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic cmp;   // compare the held tag against the incoming tag
    logic push;  // shift toward the tail, new tag enters at the head
    logic pop;   // shift toward the head, head tag leaves
  } cell_cmd_t;

endpackage

FILE: src/dtc_chan_if.sv
// Valid/ready channel carrying one payload beat of type T.
// Used with dtc_pkg::in_item_t and dtc_pkg::out_item_t.
`timescale 1ns / 1ps

interface dtc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/dtc_cell.sv
// One stack cell of the tag collector: holds one tag and its match flag.
// Depends on dtc_pkg for the broadcast command type.
`timescale 1ns / 1ps

module dtc_cell import dtc_pkg::*; #(
  parameter int TAG_BITS = 64,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  cell_cmd_t           cmd,
  input  logic [CNT_W-1:0]    count,
  input  logic [TAG_BITS-1:0] cmp_tag,
  input  logic [TAG_BITS-1:0] prev_tag,
  input  logic [TAG_BITS-1:0] next_tag,
  output logic [TAG_BITS-1:0] tag_q,
  output logic                hit_q
);

  localparam logic [CNT_W-1:0] CellIdx = CNT_W'(IDX);

  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                hit_r, hit_nxt;
  logic                occupied;

  // The head of the stack is cell 0, so cell IDX holds data when count exceeds IDX.
  assign occupied = (count > CellIdx);

  always_comb begin
    tag_nxt = tag_r;
    if (cmd.push) begin
      tag_nxt = prev_tag;
    end else if (cmd.pop) begin
      tag_nxt = next_tag;
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.cmp) begin
      hit_nxt = occupied && (tag_r == cmp_tag);
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    hit_r <= hit_nxt;
  end

  assign tag_q = tag_r;
  assign hit_q = hit_r;

endmodule

FILE: src/dtc_ctrl.sv
// Sequencer of the tag collector: accepts a beat, decides the operation,
// drives the cell chain and holds the result register. Depends on dtc_pkg.
`timescale 1ns / 1ps

module dtc_ctrl import dtc_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_BITS    = 64,
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  dtc_chan_if.sink            in_bus,
  dtc_chan_if.source          out_bus,
  input  logic                hit_any,
  input  logic [TAG_BITS-1:0] top_tag,
  output cell_cmd_t           cmd,
  output logic [CNT_W-1:0]    count_q,
  output logic [TAG_BITS-1:0] push_tag
);

  localparam logic [CNT_W-1:0] FullCount = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_DECIDE = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [CNT_W-1:0]    count_r, count_nxt, count_res;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_res;
  logic                accept, fire, do_push, do_pop;

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  // Retire only when the result register is free or being drained this cycle.
  assign fire         = (state_r == S_DECIDE) && (!out_valid_r || out_bus.ready);

  always_comb begin
    count_res    = count_r;
    do_push      = 1'b0;
    do_pop       = 1'b0;
    out_data_res = '0;
    case (op_r)
      OP_CLEAR: begin
        count_res = '0;
        out_data_res.status = ST_DONE;
      end
      OP_ADD: begin
        if (count_r == FullCount) begin
          out_data_res.status = ST_FULL;
        end else if (hit_any) begin
          out_data_res.status = ST_DUP;
        end else begin
          do_push   = 1'b1;
          count_res = count_r + CNT_W'(1);
          out_data_res.status = ST_ADDED;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          out_data_res.status = ST_EMPTY;
        end else begin
          do_pop    = 1'b1;
          count_res = count_r - CNT_W'(1);
          out_data_res.status     = ST_DONE;
          out_data_res.popped_tag = TAG_W'(top_tag);
        end
      end
      default: begin
        out_data_res.status = ST_DONE;
      end
    endcase
    out_data_res.held_tags = COUNT_W'(count_res);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          count_nxt     = count_res;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_bus.data.operation;
      tag_r <= in_bus.data.tag_value[TAG_BITS-1:0];
    end
    if (fire) begin
      out_data_r <= out_data_res;
    end
  end

  // Cells compare in the accept cycle; shifts happen when the beat retires.
  assign cmd.cmp  = accept;
  assign cmd.push = fire && do_push;
  assign cmd.pop  = fire && do_pop;

  assign count_q  = count_r;
  assign push_tag = tag_r;

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

endmodule

FILE: src/dedup_tag_collector.sv
// Top level of the deduplicating tag collector: sequencer plus a chain of
// stack cells. Depends on dtc_pkg, dtc_chan_if, dtc_ctrl and dtc_cell.
//
//   channel   dir  payload                               handshake
//   in_bus    in   operation[1:0], tag_value[63:0]       valid/ready
//   out_bus   out  status[2:0], popped_tag[63:0],        valid/ready
//                  held_tags[4:0]
//
// Each beat passes through the accept cycle, in which every cell compares
// its tag with the incoming one, and a decide cycle that may shift the chain.
// One beat is in flight at a time; a new beat is taken while the previous
// result still sits in the output register.
// The decide cycle holds while the output register is full and not drained.
// Synchronous reset empties the store at once; no clearing pass is needed.
`timescale 1ns / 1ps

module dedup_tag_collector import dtc_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_BITS    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  dtc_chan_if.sink   in_bus,
  dtc_chan_if.source out_bus
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  cell_cmd_t           cmd;
  logic [CNT_W-1:0]    count;
  logic [TAG_BITS-1:0] push_tag;
  logic [TAG_BITS-1:0] cmp_tag;
  logic [TAG_BITS-1:0] cell_tag [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hits;
  logic                hit_any;

  assign cmp_tag = in_bus.data.tag_value[TAG_BITS-1:0];
  assign hit_any = |hits;

  dtc_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .hit_any  (hit_any),
    .top_tag  (cell_tag[0]),
    .cmd      (cmd),
    .count_q  (count),
    .push_tag (push_tag)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    if (i == 0) begin : g_head
      assign prev_tag = push_tag;
    end else begin : g_body
      assign prev_tag = cell_tag[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_tag = cell_tag[i];
    end else begin : g_inner
      assign next_tag = cell_tag[i+1];
    end

    dtc_cell #(
      .TAG_BITS (TAG_BITS),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .cmp_tag  (cmp_tag),
      .prev_tag (prev_tag),
      .next_tag (next_tag),
      .tag_q    (cell_tag[i]),
      .hit_q    (hits[i])
    );
  end

endmodule

FILE: src/dtc_checker.sv
// Port-level checks of the tag collector, bound to the top level.
// Depends on dtc_pkg and dedup_tag_collector_defines.svh.
`timescale 1ns / 1ps
`include "dedup_tag_collector_defines.svh"

module dtc_checker import dtc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [TAG_W-1:0]    out_popped,
  input logic [COUNT_W-1:0]  out_count
);

  // A stalled result beat holds.
  `DTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable({out_status, out_popped, out_count}),
                   "result beat changed while stalled")

  // One beat in flight: no accept right after an accept.
  `DTC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
                   "input taken during decide cycle")

  // Only a successful pop carries a tag.
  `DTC_ASSERT_NOW(a_popped_zero, out_valid && out_status != ST_DONE, out_popped == '0,
                  "popped tag set on non-pop status")

  // Pop on empty leaves the store empty.
  `DTC_ASSERT_NOW(a_empty_count, out_valid && out_status == ST_EMPTY, out_count == '0,
                  "empty status with nonzero count")

endmodule

bind dedup_tag_collector dtc_checker u_dtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.data.status),
  .out_popped (out_bus.data.popped_tag),
  .out_count  (out_bus.data.held_tags)
);

FILE: test/dedup_tag_collector_test.sv
// Self-checking bench for dedup_tag_collector: directed and random tag traffic.
// Depends on dtc_pkg, dtc_chan_if and the dedup_tag_collector RTL.
// A mirror of the tag store predicts every result beat; a checker compares them.
`timescale 1ns / 1ps

module dedup_tag_collector_test;
  import dtc_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int TAG_BITS = 64;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam logic [TAG_W-1:0] TAG_MASK =
      (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : ((64'd1 << TAG_BITS) - 64'd1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 360;
  localparam int POOL_SIZE = 24;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int send_idle_pct;
  int recv_stall_pct;

  // Mirror of the tag store, updated at every accepted input beat
  logic [TAG_W-1:0] mirror_tags [STORE_DEPTH];
  int mirror_count;
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];
  out_item_t pending_results [$];

  dtc_chan_if #(.T(in_item_t)) in_ch ();
  dtc_chan_if #(.T(out_item_t)) out_ch ();

  dedup_tag_collector #(
    .MAX_ENTRIES(STORE_DEPTH),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_ch),
    .out_bus(out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** dedup_tag_collector: FAILED **");
      $finish;
    end
  end

  function automatic out_item_t collect_tag(input in_item_t item);
    out_item_t res;
    logic [TAG_W-1:0] tag;
    logic seen;
    res = '0;
    res.status = ST_DONE;
    tag = item.tag_value & TAG_MASK;
    seen = 1'b0;
    case (item.operation)
      OP_CLEAR: mirror_count = 0;
      OP_ADD: begin
        // a full store drops the tag without comparing
        if (mirror_count >= STORE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = 0; i < mirror_count; i++)
            if (mirror_tags[i] == tag) seen = 1'b1;
          if (seen) begin
            res.status = ST_DUP;
          end else begin
            mirror_tags[mirror_count] = tag;
            mirror_count++;
            res.status = ST_ADDED;
          end
        end
      end
      OP_POP: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          mirror_count--;
          res.popped_tag = mirror_tags[mirror_count];
        end
      end
      default: ;
    endcase
    res.held_tags = COUNT_W'(mirror_count);
    return res;
  endfunction

  task automatic score_beat(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("cycle %0d: unexpected beat status %0d tag %h count %0d",
                 cycles, got.status, got.popped_tag, got.held_tags);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.popped_tag !== want.popped_tag ||
          got.held_tags !== want.held_tags) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("cycle %0d: expected status %0d tag %h count %0d, got %0d %h %0d",
                   cycles, want.status, want.popped_tag, want.held_tags,
                   got.status, got.popped_tag, got.held_tags);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) score_beat(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold valid across back-to-back beats; drop it only for an idle gap.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag);
    in_item_t item;
    item.operation = op;
    item.tag_value = tag;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(collect_tag(item));
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && mirror_count > 0)
      return mirror_tags[$urandom_range(mirror_count - 1)];
    else if (roll < 75)
      return tag_pool[$urandom_range(POOL_SIZE - 1)];
    else
      return {$urandom, $urandom};
  endfunction

  task automatic test_empty_and_ignored();
    send_op(OP_POP, '1);
    send_op(OP_IGNORED, '1);
    send_op(OP_ADD, '0);
    send_op(OP_ADD, '1);
    send_op(OP_ADD, '1);
    send_op(OP_IGNORED, 64'h5555_5555_5555_5555);
    send_op(OP_POP, '0);
    send_op(OP_POP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OP_POP, '0);
  endtask

  task automatic test_fill_store();
    for (int i = 0; i < STORE_DEPTH; i++)
      send_op(OP_ADD, 64'h0123_4567_89AB_CDEF ^ (64'h1 << (4 * i)));
    send_op(OP_ADD, 64'hFEDC_BA98_7654_3210);
    send_op(OP_ADD, 64'h0123_4567_89AB_CDEE);
    send_op(OP_POP, '0);
    send_op(OP_ADD, 64'hFEDC_BA98_7654_3210);
    send_op(OP_CLEAR, '1);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    int unsigned roll;
    logic [OP_W-1:0] op;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      roll = $urandom_range(99);
      if (roll < 60) op = OP_ADD;
      else if (roll < 88) op = OP_POP;
      else if (roll < 95) op = OP_CLEAR;
      else op = OP_IGNORED;
      send_op(op, pick_tag());
    end
    wait_for_drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    send_idle_pct = 35;
    recv_stall_pct = 60;
    mirror_count = 0;
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_ignored();
    test_fill_store();
    test_random_traffic(35, 60);
    test_random_traffic(60, 35);
    test_random_traffic(0, 0);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** dedup_tag_collector: PASSED **");
    end else begin
      $display("** dedup_tag_collector: FAILED **");
    end
    $finish;
  end

endmodule
